### hw/rtl/qjtg_pkg.sv
// ----------------------------------------------------------------------------
// qjtg_pkg
// shared constants, types and codes of the quintic joint trajectory generator
// ----------------------------------------------------------------------------
package qjtg_pkg;

	// joint count and field widths
	localparam int MAX_JOINTS = 7;
	localparam int NUM_JOINTS = 7;
	localparam int JIDX_W     = $clog2(MAX_JOINTS);
	localparam int ANGLE_W    = 20;
	localparam int TICK_W     = 16;
	localparam int DUR_W      = 27;
	localparam int ELAPSED_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 27;

	// fixed point: tau is q0.16, s is q1.16 capped at one
	localparam int FRAC_W     = 16;
	localparam int S_W        = FRAC_W + 1;
	localparam int P_W        = 20;
	localparam int MUL_A_W    = FRAC_W;
	localparam int MUL_B_W    = P_W;
	localparam int MUL_W      = MUL_A_W + MUL_B_W;
	localparam int DIV_STEPS  = FRAC_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	// smoothstep coefficients
	localparam int COEF_T5    = 6;
	localparam int COEF_T4    = 15;
	localparam int COEF_T3    = 10;
	localparam logic [S_W-1:0] S_ONE = S_W'(1 << FRAC_W);

	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_TICK  = 1'b1
	} mode_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GOAL_J0  = 3'd0,
		REG_GOAL_J1  = 3'd1,
		REG_GOAL_J2  = 3'd2,
		REG_GOAL_J3  = 3'd3,
		REG_GOAL_J4  = 3'd4,
		REG_GOAL_J5  = 3'd5,
		REG_GOAL_J6  = 3'd6,
		REG_DURATION = 3'd7
	} cfg_reg_e;

	localparam angle_t GOAL_RESET [MAX_JOINTS] = '{
		20'sd0, -20'sd51472, 20'sd0, -20'sd154416, 20'sd0, 20'sd102944, 20'sd51472
	};
	localparam logic [DUR_W-1:0] DUR_RESET = 27'd10000000;

	typedef struct packed {
		mode_e               mode;
		logic [TICK_W-1:0]   tick_us;
		angle_t              pos_j0;
		angle_t              pos_j1;
		angle_t              pos_j2;
		angle_t              pos_j3;
		angle_t              pos_j4;
		angle_t              pos_j5;
		angle_t              pos_j6;
	} in_item_t;

	typedef struct packed {
		angle_t cmd_j0;
		angle_t cmd_j1;
		angle_t cmd_j2;
		angle_t cmd_j3;
		angle_t cmd_j4;
		angle_t cmd_j5;
		angle_t cmd_j6;
		logic   arrived;
	} out_item_t;

	// lane issue control
	typedef struct packed {
		logic go;
		logic arrived;
	} lane_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_POLY,
		ST_LANES,
		ST_MERGE
	} top_state_e;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SQUARE,
		PH_CUBE,
		PH_PRODUCT,
		PH_CAP
	} poly_phase_e;

endpackage

### hw/rtl/qjtg_in_if.sv
// ----------------------------------------------------------------------------
// qjtg_in_if
// input item channel: valid, ready and one set of joint samples or a tick
// ----------------------------------------------------------------------------
interface qjtg_in_if;
	import qjtg_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

### hw/rtl/qjtg_out_if.sv
// ----------------------------------------------------------------------------
// qjtg_out_if
// result channel: valid, ready and one set of joint commands
// ----------------------------------------------------------------------------
interface qjtg_out_if;
	import qjtg_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

### hw/rtl/qjtg_cfg_if.sv
// ----------------------------------------------------------------------------
// qjtg_cfg_if
// register write channel: valid, ready, register index and write data
// ----------------------------------------------------------------------------
interface qjtg_cfg_if;
	import qjtg_pkg::*;

	logic                  valid;
	logic                  ready;
	cfg_reg_e              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);

endinterface

### hw/rtl/qjtg_div.sv
// ----------------------------------------------------------------------------
// qjtg_div
// restoring divider, one quotient bit a cycle: tau = num * 2^16 / den, num < den
// ----------------------------------------------------------------------------
module qjtg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [qjtg_pkg::DUR_W-1:0]   num,
	input  logic [qjtg_pkg::DUR_W-1:0]   den,
	output logic                         done,
	output logic [qjtg_pkg::FRAC_W-1:0]  quot
);
	import qjtg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DUR_W-1:0]     rem_q;
	logic [FRAC_W-1:0]    quot_q;
	logic [DUR_W:0]       shifted;
	logic [DUR_W:0]       diff;
	logic                 ge;

	always_comb begin
		shifted = {rem_q, 1'b0};
		ge      = shifted >= {1'b0, den};
		diff    = shifted - {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### hw/rtl/qjtg_poly.sv
// ----------------------------------------------------------------------------
// qjtg_poly
// smoothstep s = 6tau^5 - 15tau^4 + 10tau^3 over one shared multiplier
// ----------------------------------------------------------------------------
module qjtg_poly (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [qjtg_pkg::FRAC_W-1:0] tau,
	output logic                        done,
	output logic [qjtg_pkg::S_W-1:0]    s
);
	import qjtg_pkg::*;

	poly_phase_e          phase_q;
	poly_phase_e          phase_d;
	logic                 done_q;
	logic [FRAC_W-1:0]    tau_q;
	logic [P_W-1:0]       p_q;
	logic [MUL_W-1:0]     prod_q;
	logic [S_W-1:0]       s_q;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [FRAC_W-1:0]    prod_hi;
	logic [P_W:0]         p_sum;
	logic [MUL_W-FRAC_W-1:0] s_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == PH_CAP);
		end
	end

	// next phase and multiplier operand select
	always_comb begin
		phase_d = phase_q;
		mul_a   = tau_q;
		mul_b   = MUL_B_W'(tau_q);
		case (phase_q)
			PH_IDLE: begin
				if (start) phase_d = PH_SQUARE;
			end
			PH_SQUARE: begin
				phase_d = PH_CUBE;
			end
			PH_CUBE: begin
				mul_a   = prod_hi;
				phase_d = PH_PRODUCT;
			end
			PH_PRODUCT: begin
				mul_a   = prod_hi;
				mul_b   = p_q;
				phase_d = PH_CAP;
			end
			PH_CAP: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign prod_hi = prod_q[2*FRAC_W-1:FRAC_W];
	assign s_raw   = prod_q[MUL_W-1:FRAC_W];

	// p = 6 t2 - 15 tau + 10, always positive and at most ten, so it fits in 20 bits
	assign p_sum = ((P_W+1)'(COEF_T3) << FRAC_W)
		+ ((P_W+1)'(prod_hi) * (P_W+1)'(COEF_T5))
		- ((P_W+1)'(tau_q) * (P_W+1)'(COEF_T4));

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) tau_q <= tau;
		if (phase_q == PH_SQUARE || phase_q == PH_CUBE || phase_q == PH_PRODUCT) begin
			prod_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
		end
		if (phase_q == PH_CUBE) p_q <= p_sum[P_W-1:0];
		if (phase_q == PH_CAP) begin
			s_q <= (s_raw > (MUL_W-FRAC_W)'(S_ONE)) ? S_ONE : s_raw[S_W-1:0];
		end
	end

	assign done = done_q;
	assign s    = s_q;

endmodule

### hw/rtl/qjtg_lane.sv
// ----------------------------------------------------------------------------
// qjtg_lane
// one joint: cmd = start + floor((goal - start) * s / 2^16), or goal on arrival
// ----------------------------------------------------------------------------
module qjtg_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qjtg_pkg::lane_ctl_t       ctl,
	input  qjtg_pkg::angle_t          goal,
	input  qjtg_pkg::angle_t          origin,
	input  logic [qjtg_pkg::S_W-1:0]  s,
	output logic                      vld,
	output qjtg_pkg::angle_t          cmd
);
	import qjtg_pkg::*;

	localparam int D_W  = ANGLE_W + 1;
	localparam int SM_W = S_W + 1;
	localparam int PR_W = D_W + SM_W;
	localparam int SH_W = PR_W - FRAC_W;

	logic                   vld_s1, vld_s2, vld_s3;
	logic                   arr_s1, arr_s2;
	logic signed [D_W-1:0]  diff_s1;
	logic signed [PR_W-1:0] prod_s2;
	angle_t                 cmd_s3;
	logic [SH_W-1:0]        sum;

	// arithmetic shift of the product is the floor towards minus infinity
	assign sum = SH_W'(origin) + prod_s2[PR_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= ctl.go;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			diff_s1 <= D_W'(goal) - D_W'(origin);
			arr_s1  <= ctl.arrived;
		end
		if (vld_s1) begin
			prod_s2 <= PR_W'(diff_s1) * PR_W'($signed({1'b0, s}));
			arr_s2  <= arr_s1;
		end
		if (vld_s2) cmd_s3 <= arr_s2 ? goal : sum[ANGLE_W-1:0];
	end

	assign vld = vld_s3;
	assign cmd = cmd_s3;

endmodule

### hw/rtl/quintic_joint_trajectory_gen_unit.sv
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_gen_unit - seven-joint minimum-jerk trajectory generator
// a tick before arrival runs the 16-step divider and the shared smoothstep
// multiplier before the lanes, an arrived tick skips both and the lanes give the
// goals; a start item gives no result; items are taken only while idle, so a
// tick is merged before the next item; a result still waiting holds the merge step
// reset clears control, start angles and elapsed time and loads the default duration and goals
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_gen_unit (
	input  logic        clk,
	input  logic        arst_n,
	qjtg_in_if.sink     req,
	qjtg_out_if.source  rsp,
	qjtg_cfg_if.sink    cfg
);
	import qjtg_pkg::*;

	// configuration registers
	angle_t                 goal_q [MAX_JOINTS];
	logic [DUR_W-1:0]       duration_q;

	// trajectory state
	angle_t                 start_q [MAX_JOINTS];
	logic [ELAPSED_W-1:0]   elapsed_q;
	logic                   arrived_q;

	// sequencer
	top_state_e             state_q;
	top_state_e             state_d;
	logic                   accept;
	logic                   arr_cmp;
	logic                   div_start;
	logic                   div_done;
	logic [FRAC_W-1:0]      tau;
	logic                   poly_start;
	logic                   poly_done;
	logic [S_W-1:0]         s;
	lane_ctl_t              lane_ctl;
	logic [MAX_JOINTS-1:0]  lane_vld;
	angle_t                 cmd_lane [MAX_JOINTS];
	angle_t                 pos_in [MAX_JOINTS];
	logic                   merge_ld;
	logic [ELAPSED_W:0]     elapsed_sum;

	// result register
	logic                   out_valid_q;
	out_item_t              out_q;
	out_item_t              merged;

	// register writes are always taken; they must only come while the block is idle, which the block does not enforce
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_JOINTS; j++) begin
				goal_q[j] <= GOAL_RESET[j];
			end
			duration_q <= DUR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DURATION: duration_q <= cfg.data;
				default:      goal_q[JIDX_W'(cfg.index)] <= cfg.data[ANGLE_W-1:0];
			endcase
		end
	end

	// measured angles of a start item, by joint
	assign pos_in[0] = req.data.pos_j0;
	assign pos_in[1] = req.data.pos_j1;
	assign pos_in[2] = req.data.pos_j2;
	assign pos_in[3] = req.data.pos_j3;
	assign pos_in[4] = req.data.pos_j4;
	assign pos_in[5] = req.data.pos_j5;
	assign pos_in[6] = req.data.pos_j6;

	assign accept      = req.valid && req.ready;
	assign elapsed_sum = (ELAPSED_W+1)'(elapsed_q) + (ELAPSED_W+1)'(req.data.tick_us);
	assign arr_cmp     = elapsed_q >= ELAPSED_W'(duration_q);

	// start items capture angles and rewind time; ticks advance saturating time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_JOINTS; j++) begin
				start_q[j] <= '0;
			end
			elapsed_q <= '0;
			arrived_q <= 1'b0;
		end else begin
			if (accept) begin
				if (req.data.mode == MODE_START) begin
					for (int j = 0; j < NUM_JOINTS; j++) begin
						start_q[j] <= pos_in[j];
					end
					elapsed_q <= '0;
				end else begin
					elapsed_q <= elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
				end
			end
			if (state_q == ST_CHECK) arrived_q <= arr_cmp;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// idle -> check -> divide -> smoothstep -> lanes -> merge; arrival skips the maths
	always_comb begin
		state_d          = state_q;
		req.ready        = 1'b0;
		div_start        = 1'b0;
		poly_start       = 1'b0;
		lane_ctl.go      = 1'b0;
		lane_ctl.arrived = 1'b0;
		merge_ld         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.data.mode == MODE_TICK) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (arr_cmp) begin
					lane_ctl.go      = 1'b1;
					lane_ctl.arrived = 1'b1;
					state_d          = ST_LANES;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					poly_start = 1'b1;
					state_d    = ST_POLY;
				end
			end
			ST_POLY: begin
				if (poly_done) begin
					lane_ctl.go = 1'b1;
					state_d     = ST_LANES;
				end
			end
			ST_LANES: begin
				if (&lane_vld) state_d = ST_MERGE;
			end
			ST_MERGE: begin
				// wait for the result register to free up
				if (!out_valid_q || rsp.ready) begin
					merge_ld = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// tau = elapsed / duration; elapsed is below duration here, so 27 bits suffice
	qjtg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed_q[DUR_W-1:0]),
		.den    (duration_q),
		.done   (div_done),
		.quot   (tau)
	);

	qjtg_poly u_poly (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (poly_start),
		.tau    (tau),
		.done   (poly_done),
		.s      (s)
	);

	// one lane per joint; joints past the configured count read as zero
	for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
		if (j < NUM_JOINTS) begin : g_on
			qjtg_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (lane_ctl),
				.goal   (goal_q[j]),
				.origin (start_q[j]),
				.s      (s),
				.vld    (lane_vld[j]),
				.cmd    (cmd_lane[j])
			);
		end else begin : g_off
			assign lane_vld[j] = 1'b1;
			assign cmd_lane[j] = '0;
		end
	end

	// merge the lane results into one transaction
	always_comb begin
		merged.cmd_j0  = cmd_lane[0];
		merged.cmd_j1  = cmd_lane[1];
		merged.cmd_j2  = cmd_lane[2];
		merged.cmd_j3  = cmd_lane[3];
		merged.cmd_j4  = cmd_lane[4];
		merged.cmd_j5  = cmd_lane[5];
		merged.cmd_j6  = cmd_lane[6];
		merged.arrived = arrived_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (merge_ld) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (merge_ld) out_q <= merged;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// divider and smoothstep only report back in their own step
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside divide step");

	a_poly_done_in_poly: assert property (@(posedge clk) disable iff (!arst_n)
		poly_done |-> state_q == ST_POLY)
		else $error("smoothstep done outside smoothstep step");

	// all lanes run in lockstep and only finish while the sequencer waits on them
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_vld[0] |-> (&lane_vld) && state_q == ST_LANES)
		else $error("lanes out of step with sequencer");

	a_check_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> $past(accept) && $past(req.data.mode == MODE_TICK))
		else $error("arrival check without a tick transaction");

	a_merge_loads: assert property (@(posedge clk) disable iff (!arst_n)
		merge_ld |=> out_valid_q && state_q == ST_IDLE)
		else $error("merged result not presented");

endmodule
